### sv/ddwm_pkg.sv
// shared constants, register codes and the configuration struct of the wheel mixer
// no dependencies; every other file of the block imports this package
package ddwm_pkg;

   localparam int SPEED_WIDTH_DEF = 16;
   localparam int AGE_WIDTH_DEF   = 16;

   // request command codes
   localparam logic CMD_VELOCITY = 1'b0;
   localparam logic CMD_TICK     = 1'b1;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_TRACK = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_RADIUS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SPEED  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_GAIN  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_GAIN = 3'd5;

   localparam logic [15:0] TIMEOUT_RST    = 16'd25;
   localparam logic [15:0] HALF_TRACK_RST = 16'd13271;
   localparam logic [15:0] INV_RADIUS_RST = 16'd4697;
   localparam logic [14:0] MAX_SPEED_RST  = 15'd2560;
   localparam logic [15:0] LEFT_GAIN_RST  = 16'd16384;
   localparam logic [15:0] RIGHT_GAIN_RST = 16'd16384;

   // serial multiplier: magnitude operand by 16-bit magnitude operand
   localparam int MUL_A_W = 34;
   localparam int MUL_B_W = 16;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // rounding shifts of the two scaling steps
   localparam int SCALE_SHIFT = 16;
   localparam int GAIN_SHIFT  = 22;

   typedef struct packed {
      logic [15:0] timeout_ticks;
      logic [15:0] half_track;
      logic [15:0] inv_radius;
      logic [14:0] max_speed;
      logic [15:0] left_gain;
      logic [15:0] right_gain;
   } cfg_type;

endpackage

### sv/ddwm_intf.sv
// valid/ready channel interfaces of the wheel mixer: request, response, register write
// depends on ddwm_pkg
interface ddwm_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [15:0] linear_velocity;
   logic [15:0] angular_velocity;

   modport source (output valid, command, linear_velocity, angular_velocity, input ready);
   modport sink   (input valid, command, linear_velocity, angular_velocity, output ready);
endinterface

interface ddwm_rsp_if #(parameter int SPEED_WIDTH = 16);
   logic                   valid;
   logic                   ready;
   logic [SPEED_WIDTH-1:0] left_speed;
   logic [SPEED_WIDTH-1:0] right_speed;
   logic                   timed_out;

   modport source (output valid, left_speed, right_speed, timed_out, input ready);
   modport sink   (input valid, left_speed, right_speed, timed_out, output ready);
endinterface

interface ddwm_csr_if import ddwm_pkg::*; ;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### sv/diff_drive_wheel_mixer_top.sv
// top level of the differential-drive wheel mixer
// depends on ddwm_pkg, ddwm_intf, ddwm_csr and ddwm_serial_mul
//
// Turns the last velocity command into left and right wheel speeds. A request
// transaction with command 0 stores linear and angular velocity (signed Q8.8),
// clears the command age and marks a command as held; it returns nothing.
// A request with command 1 is a tick: the age advances
// (saturating), and if no command is held or the age is past timeout_ticks
// both velocities are taken as zero and timed_out is set. With w the negated
// angular velocity, left = (v + w*half_track)*inverse_radius*left_gain and
// right = (v - w*half_track)*inverse_radius*right_gain, each product rounded
// to nearest with ties away from zero and clamped to +-max_speed (or the
// largest value of SPEED_WIDTH). One response transaction per tick. All
// products run through one bit-serial 34x16 multiplier, five products per
// tick, and the request side is held from acceptance of a tick until its
// response is loaded. The finished response sits in an output register, so
// the next request is taken while it waits.
module diff_drive_wheel_mixer_top import ddwm_pkg::*; #(
   parameter int SPEED_WIDTH = SPEED_WIDTH_DEF,
   parameter int AGE_WIDTH   = AGE_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   ddwm_req_if.sink    req_ch,
   ddwm_rsp_if.source  rsp_ch,
   ddwm_csr_if.sink    csr_ch
);

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_TERM  = 3'd1;
   localparam logic [2:0] ST_SCALE = 3'd2;
   localparam logic [2:0] ST_GAIN  = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   localparam int CMP_W = (AGE_WIDTH > 16) ? AGE_WIDTH : 16;
   localparam int MAG_W = 32;
   localparam logic [MAG_W-1:0] SPEED_POS_MAX =
      MAG_W'((64'd1 << (SPEED_WIDTH - 1)) - 64'd1);
   localparam logic [MUL_P_W-1:0] SCALE_HALF = MUL_P_W'(1) << (SCALE_SHIFT - 1);
   localparam logic [MUL_P_W-1:0] GAIN_HALF  = MUL_P_W'(1) << (GAIN_SHIFT - 1);

   function automatic logic [MUL_A_W-1:0] abs_sum(input logic [MUL_A_W-1:0] x);
      return x[MUL_A_W-1] ? (~x + MUL_A_W'(1)) : x;
   endfunction

   cfg_type cfg;

   logic [2:0]             state_ff, state_in;
   logic [AGE_WIDTH-1:0]   age_ff, age_in;
   logic                   held_ff, held_in;
   logic [15:0]            held_lin_ff, held_lin_in;
   logic [15:0]            held_ang_ff, held_ang_in;
   logic [15:0]            v_ff, v_in;
   logic                   w_neg_ff, w_neg_in;
   logic                   timed_out_ff, timed_out_in;
   logic                   sign_ff, sign_in;
   logic                   side_ff, side_in;
   logic [MUL_A_W-1:0]     s_r_ff, s_r_in;
   logic [SPEED_WIDTH-1:0] left_ff, left_in;
   logic [SPEED_WIDTH-1:0] right_ff, right_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SPEED_WIDTH-1:0] rsp_left_ff, rsp_left_in;
   logic [SPEED_WIDTH-1:0] rsp_right_ff, rsp_right_in;
   logic                   rsp_to_ff, rsp_to_in;

   logic                   mul_start;
   logic [MUL_A_W-1:0]     mul_a;
   logic [MUL_B_W-1:0]     mul_b;
   logic                   mul_done;
   logic [MUL_P_W-1:0]     mul_p;

   logic                   req_fire;
   logic [AGE_WIDTH-1:0]   age_sat;
   logic                   cmd_valid;
   logic [16:0]            ang_ext, ang_mag;
   logic                   w_neg;
   logic [MUL_A_W-1:0]     term, v_shift, s_l, s_r;
   logic [MUL_P_W-1:0]     scale_round, gain_round;
   logic [MUL_A_W-1:0]     scaled;
   logic [15:0]            gain_sel, gain_mag;
   logic [MAG_W-1:0]       spd_mag, limit, clamped, spd_signed;
   logic [SPEED_WIDTH-1:0] spd_out;
   logic                   rsp_load;

   ddwm_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   ddwm_serial_mul #(
      .A_W (MUL_A_W),
      .B_W (MUL_B_W)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (mul_p)
   );

   // handshakes
   assign req_ch.ready      = (state_ff == ST_IDLE);
   assign req_fire          = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.left_speed = rsp_left_ff;
   assign rsp_ch.right_speed = rsp_right_ff;
   assign rsp_ch.timed_out  = rsp_to_ff;

   always_comb begin
      // command age and validity as seen by a tick
      age_sat   = (age_ff == {AGE_WIDTH{1'b1}}) ? age_ff : age_ff + AGE_WIDTH'(1);
      cmd_valid = held_ff && (CMP_W'(age_sat) <= CMP_W'(cfg.timeout_ticks));

      // w = -angular: magnitude of angular, sign flipped
      ang_ext = {held_ang_ff[15], held_ang_ff};
      ang_mag = ang_ext[16] ? (~ang_ext + 17'd1) : ang_ext;
      w_neg   = !held_ang_ff[15] && (held_ang_ff != 16'd0);

      // v<<16 +- w*half_track, exact in 34 bits
      term    = w_neg_ff ? (~mul_p[MUL_A_W-1:0] + MUL_A_W'(1)) : mul_p[MUL_A_W-1:0];
      v_shift = {{2{v_ff[15]}}, v_ff, 16'd0};
      s_l     = v_shift + term;
      s_r     = v_shift - term;

      // first rounding, magnitude domain
      scale_round = mul_p + SCALE_HALF;
      scaled      = MUL_A_W'(scale_round >> SCALE_SHIFT);

      gain_sel = side_ff ? cfg.right_gain : cfg.left_gain;
      gain_mag = gain_sel[15] ? (~gain_sel + 16'd1) : gain_sel;

      // second rounding, clamp, sign
      gain_round = mul_p + GAIN_HALF;
      spd_mag    = MAG_W'(gain_round >> GAIN_SHIFT);
      limit      = (MAG_W'(cfg.max_speed) > SPEED_POS_MAX) ? SPEED_POS_MAX
                                                           : MAG_W'(cfg.max_speed);
      clamped    = (spd_mag > limit) ? limit : spd_mag;
      spd_signed = sign_ff ? (~clamped + MAG_W'(1)) : clamped;
      spd_out    = spd_signed[SPEED_WIDTH-1:0];
   end

   // sequencer: term, then scale and gain for the left and the right side
   always_comb begin
      state_in     = state_ff;
      age_in       = age_ff;
      held_in      = held_ff;
      held_lin_in  = held_lin_ff;
      held_ang_in  = held_ang_ff;
      v_in         = v_ff;
      w_neg_in     = w_neg_ff;
      timed_out_in = timed_out_ff;
      sign_in      = sign_ff;
      side_in      = side_ff;
      s_r_in       = s_r_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      mul_start    = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      rsp_load     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_ch.command == CMD_VELOCITY) begin
                  held_lin_in = req_ch.linear_velocity;
                  held_ang_in = req_ch.angular_velocity;
                  age_in      = '0;
                  held_in     = 1'b1;
               end else begin
                  age_in       = age_sat;
                  timed_out_in = !cmd_valid;
                  v_in         = cmd_valid ? held_lin_ff : 16'd0;
                  w_neg_in     = cmd_valid && w_neg;
                  mul_start    = 1'b1;
                  mul_a        = cmd_valid ? MUL_A_W'(ang_mag) : '0;
                  mul_b        = cfg.half_track;
                  state_in     = ST_TERM;
               end
            end
         end
         ST_TERM: begin
            if (mul_done) begin
               s_r_in    = s_r;
               sign_in   = s_l[MUL_A_W-1];
               side_in   = 1'b0;
               mul_start = 1'b1;
               mul_a     = abs_sum(s_l);
               mul_b     = cfg.inv_radius;
               state_in  = ST_SCALE;
            end
         end
         ST_SCALE: begin
            if (mul_done) begin
               sign_in   = sign_ff ^ gain_sel[15];
               mul_start = 1'b1;
               mul_a     = scaled;
               mul_b     = gain_mag;
               state_in  = ST_GAIN;
            end
         end
         ST_GAIN: begin
            if (mul_done) begin
               if (!side_ff) begin
                  // left done, start the right side
                  left_in   = spd_out;
                  side_in   = 1'b1;
                  sign_in   = s_r_ff[MUL_A_W-1];
                  mul_start = 1'b1;
                  mul_a     = abs_sum(s_r_ff);
                  mul_b     = cfg.inv_radius;
                  state_in  = ST_SCALE;
               end else begin
                  right_in = spd_out;
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            // wait for the output register to be free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;
      rsp_to_in    = rsp_to_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      if (rsp_load) begin
         rsp_left_in  = left_ff;
         rsp_right_in = right_ff;
         rsp_to_in    = timed_out_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         age_ff       <= '0;
         held_ff      <= 1'b0;
         held_lin_ff  <= '0;
         held_ang_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         age_ff       <= age_in;
         held_ff      <= held_in;
         held_lin_ff  <= held_lin_in;
         held_ang_ff  <= held_ang_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers, no reset needed
   always_ff @(posedge clock) begin
      v_ff         <= v_in;
      w_neg_ff     <= w_neg_in;
      timed_out_ff <= timed_out_in;
      sign_ff      <= sign_in;
      side_ff      <= side_in;
      s_r_ff       <= s_r_in;
      left_ff      <= left_in;
      right_ff     <= right_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
      rsp_to_ff    <= rsp_to_in;
   end

`ifndef SYNTH
   // multiplier results only show up while the sequencer waits for one
   a_mul_done_state: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == ST_TERM || state_ff == ST_SCALE || state_ff == ST_GAIN))
      else $error("multiplier finished outside a product state");

   // a tick starts the term product in the next cycle
   a_tick_starts: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_ch.command == CMD_TICK) |=> (state_ff == ST_TERM))
      else $error("tick did not start the wheel computation");

   // a velocity command restarts the age and marks a command held
   a_cmd_held: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_ch.command == CMD_VELOCITY) |=> (age_ff == '0 && held_ff))
      else $error("velocity command not captured");
`endif

endmodule

### sv/ddwm_csr.sv
// configuration register bank of the wheel mixer
// depends on ddwm_pkg and ddwm_intf
module ddwm_csr import ddwm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   ddwm_csr_if.sink csr_ch,
   output cfg_type cfg
);

   cfg_type cfg_ff, cfg_in;

   assign csr_ch.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_TIMEOUT:    cfg_in.timeout_ticks = csr_ch.data;
            CSR_HALF_TRACK: cfg_in.half_track    = csr_ch.data;
            CSR_INV_RADIUS: cfg_in.inv_radius    = csr_ch.data;
            CSR_MAX_SPEED:  cfg_in.max_speed     = csr_ch.data[14:0];
            CSR_LEFT_GAIN:  cfg_in.left_gain     = csr_ch.data;
            CSR_RIGHT_GAIN: cfg_in.right_gain    = csr_ch.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ticks <= TIMEOUT_RST;
         cfg_ff.half_track    <= HALF_TRACK_RST;
         cfg_ff.inv_radius    <= INV_RADIUS_RST;
         cfg_ff.max_speed     <= MAX_SPEED_RST;
         cfg_ff.left_gain     <= LEFT_GAIN_RST;
         cfg_ff.right_gain    <= RIGHT_GAIN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### sv/ddwm_serial_mul.sv
// bit-serial unsigned shift-add multiplier, one multiplier bit per cycle
// depends on ddwm_pkg for default widths
module ddwm_serial_mul import ddwm_pkg::*; #(
   parameter int A_W = MUL_A_W,
   parameter int B_W = MUL_B_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [A_W-1:0]   a,
   input  logic [B_W-1:0]   b,
   output logic             done,
   output logic [A_W+B_W-1:0] product
);

   localparam int P_W   = A_W + B_W;
   localparam int CNT_W = $clog2(B_W + 1);

   logic [A_W-1:0]   a_ff, a_in;
   logic [P_W-1:0]   p_ff, p_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [A_W:0]     sum;

   assign done    = done_ff;
   assign product = p_ff;

   always_comb begin
      // upper half accumulates, lower half shifts out the multiplier bits
      sum     = {1'b0, p_ff[P_W-1:B_W]} + (p_ff[0] ? {1'b0, a_ff} : {(A_W+1){1'b0}});
      a_in    = a_ff;
      p_in    = p_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         a_in   = a;
         p_in   = {{A_W{1'b0}}, b};
         cnt_in = CNT_W'(B_W);
      end else if (cnt_ff != '0) begin
         p_in    = {sum, p_ff[B_W-1:1]};
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      p_ff <= p_in;
   end

endmodule
